FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the RTL files, included by sorted_index_range_select
// Clocked property checks; clk and rst_n are taken from the enclosing module.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property, ignored while reset is held
`define ASSERT_CLKD(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property at every edge, reset included
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/sirs_pkg.sv
// ----------------------------------------------------------------------------
// sirs_pkg
// Types and codes shared by the sorted index range select block.
// ----------------------------------------------------------------------------
`default_nettype none

package sirs_pkg;

    localparam int WORD_W = 64;
    localparam int OP_W   = 3;
    localparam int KIND_W = 3;

    // compare operators
    localparam logic [OP_W-1:0] OP_EQ = 3'd0;
    localparam logic [OP_W-1:0] OP_LT = 3'd1;
    localparam logic [OP_W-1:0] OP_LE = 3'd2;
    localparam logic [OP_W-1:0] OP_GT = 3'd3;
    localparam logic [OP_W-1:0] OP_GE = 3'd4;

    // result kinds
    localparam logic [KIND_W-1:0] KIND_LOADED   = 3'd0;
    localparam logic [KIND_W-1:0] KIND_DROPPED  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_REJECTED = 3'd2;
    localparam logic [KIND_W-1:0] KIND_MATCH    = 3'd3;
    localparam logic [KIND_W-1:0] KIND_NOMATCH  = 3'd4;

    // one stored posting
    typedef struct packed {
        logic signed [WORD_W-1:0] key;
        logic [WORD_W-1:0]        vid;
        logic [WORD_W-1:0]        from_time;
        logic                     has_to;
        logic [WORD_W-1:0]        to_time;
        logic [WORD_W-1:0]        commit;
    } entry_t;

    // compare unit status
    typedef struct packed {
        logic lt;
        logic eq;
        logic gt;
        logic sel;
    } cmp_res_t;

endpackage

`default_nettype wire

FILE: rtl/sirs_ram.sv
// ----------------------------------------------------------------------------
// sirs_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module sirs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

FILE: rtl/sirs_cmp.sv
// ----------------------------------------------------------------------------
// sirs_cmp
// Shared signed compare unit: key against the low operand and upper bound.
// ----------------------------------------------------------------------------
`default_nettype none

module sirs_cmp (
    input  wire logic signed [sirs_pkg::WORD_W-1:0] key,
    input  wire logic signed [sirs_pkg::WORD_W-1:0] bound_lo,
    input  wire logic signed [sirs_pkg::WORD_W-1:0] bound_hi,
    input  wire logic        [sirs_pkg::OP_W-1:0]   op,
    input  wire logic                               has_hi,
    output sirs_pkg::cmp_res_t                      res
);

    logic accept;
    logic hi_ok;

    always_comb
    begin
        res.lt = key < bound_lo;
        res.eq = key == bound_lo;
        res.gt = key > bound_lo;
        case (op)
            sirs_pkg::OP_EQ: accept = res.eq;
            sirs_pkg::OP_LT: accept = res.lt;
            sirs_pkg::OP_LE: accept = res.lt || res.eq;
            sirs_pkg::OP_GT: accept = res.gt;
            sirs_pkg::OP_GE: accept = res.gt || res.eq;
            default:         accept = 1'b0;
        endcase
        // upper bound is inclusive
        hi_ok   = !has_hi || !(key > bound_hi);
        res.sel = accept && hi_ok;
    end

endmodule

`default_nettype wire

FILE: rtl/sorted_index_range_select.sv
// A load beat gives its result in the cycle after it is accepted.
// A query scans the N stored postings in order, then gives its last result.
// Throughput: one load per cycle unless the output stalls; a query holds input until its scan
// ends, as the single RAM read port and compare unit visit one posting per cycle unless held.
// Reset: the posting count and output valid clear at once; table contents are not cleared.
// ----------------------------------------------------------------------------
// sorted_index_range_select
// Sorted posting table with an ordered load and a sequential range scan.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module sorted_index_range_select #(
    parameter int TABLE_DEPTH = 64
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    // input channel
    input  wire logic                                in_valid,
    output logic                                     in_stall,
    input  wire logic                                mode,
    input  wire logic                                restart_table,
    input  wire logic signed [sirs_pkg::WORD_W-1:0]  key_value,
    input  wire logic        [sirs_pkg::WORD_W-1:0]  vertex_num,
    input  wire logic        [sirs_pkg::WORD_W-1:0]  valid_from,
    input  wire logic                                has_valid_to,
    input  wire logic        [sirs_pkg::WORD_W-1:0]  valid_to,
    input  wire logic        [sirs_pkg::WORD_W-1:0]  commit_num,
    input  wire logic        [sirs_pkg::OP_W-1:0]    compare_op,
    input  wire logic signed [sirs_pkg::WORD_W-1:0]  bound_low,
    input  wire logic                                has_bound_high,
    input  wire logic signed [sirs_pkg::WORD_W-1:0]  bound_high,
    // output channel
    output logic                                     out_valid,
    input  wire logic                                out_stall,
    output logic             [sirs_pkg::KIND_W-1:0]  result_kind,
    output logic                                     last_result,
    output logic signed      [sirs_pkg::WORD_W-1:0]  out_key,
    output logic             [sirs_pkg::WORD_W-1:0]  out_vertex_id,
    output logic             [sirs_pkg::WORD_W-1:0]  out_valid_from,
    output logic                                     out_has_valid_to,
    output logic             [sirs_pkg::WORD_W-1:0]  out_valid_to,
    output logic             [sirs_pkg::WORD_W-1:0]  out_commit_seq
);

    // RAM address width, and count width able to hold the full depth
    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_SCAN
    } state_t;

    state_t                                state_reg;
    logic [CW-1:0]                         count_reg;
    logic [CW-1:0]                         idx_reg;
    logic [CW-1:0]                         idx_next;
    logic signed [sirs_pkg::WORD_W-1:0]    last_key_reg;
    logic [sirs_pkg::WORD_W-1:0]           last_vid_reg;

    // query operands held for the scan
    logic [sirs_pkg::OP_W-1:0]             op_reg;
    logic signed [sirs_pkg::WORD_W-1:0]    lo_reg;
    logic                                  has_hi_reg;
    logic signed [sirs_pkg::WORD_W-1:0]    hi_reg;

    // one match held back until the next one (or the end) says whether it is last
    sirs_pkg::entry_t                      pend_reg;
    logic                                  pend_valid_reg;

    // output register
    logic                                  out_valid_reg;
    logic [sirs_pkg::KIND_W-1:0]           out_kind_reg;
    logic                                  out_last_reg;
    sirs_pkg::entry_t                      out_entry_reg;

    sirs_pkg::entry_t                      wr_entry;
    sirs_pkg::entry_t                      rd_entry;
    sirs_pkg::cmp_res_t                    cmp_res;
    logic signed [sirs_pkg::WORD_W-1:0]    cmp_key;
    logic signed [sirs_pkg::WORD_W-1:0]    cmp_lo;

    logic          out_free;
    logic          in_acc;
    logic [CW-1:0] eff_count;
    logic          load_full;
    logic          load_bad;
    logic          wr_en;
    logic          scan_done;
    logic          hit;
    logic          scan_hold;
    logic          emit_beat;

    // ---------------------------------------------------------------------
    // Handshake: the output register frees when empty or its beat is taken
    // ---------------------------------------------------------------------
    assign out_free = !out_valid_reg || !out_stall;
    assign in_stall = (state_reg != ST_IDLE) || !out_free;
    assign in_acc   = in_valid && !in_stall;

    // ---------------------------------------------------------------------
    // Load checks. The compare unit is shared: during a load it orders the
    // last stored key against the incoming key, during a scan it tests the
    // stored key against the query bounds.
    // ---------------------------------------------------------------------
    assign cmp_key = (state_reg == ST_SCAN) ? rd_entry.key : last_key_reg;
    assign cmp_lo  = (state_reg == ST_SCAN) ? lo_reg : key_value;

    sirs_cmp u_cmp (
        .key      (cmp_key),
        .bound_lo (cmp_lo),
        .bound_hi (hi_reg),
        .op       (op_reg),
        .has_hi   (has_hi_reg),
        .res      (cmp_res)
    );

    // restart empties the table first, so such a load always lands
    assign eff_count = restart_table ? '0 : count_reg;
    // full check wins over the order check
    assign load_full = eff_count == DEPTH_C;
    assign load_bad  = (eff_count != '0)
                       && (cmp_res.gt || (cmp_res.eq && (last_vid_reg > vertex_num)));
    assign wr_en     = in_acc && !mode && !load_full && !load_bad;

    always_comb
    begin
        wr_entry.key       = key_value;
        wr_entry.vid       = vertex_num;
        wr_entry.from_time = valid_from;
        wr_entry.has_to    = has_valid_to;
        wr_entry.to_time   = valid_to;
        wr_entry.commit    = commit_num;
    end

    // ---------------------------------------------------------------------
    // Scan sequencing. The read address is the next index, so the RAM output
    // always belongs to idx_reg; holding the index re-reads the same entry.
    // ---------------------------------------------------------------------
    assign scan_done = idx_reg == count_reg;
    assign hit       = !scan_done && cmp_res.sel;
    assign scan_hold = (state_reg == ST_SCAN)
                       && (scan_done ? !out_free : (hit && pend_valid_reg && !out_free));

    // a new beat enters the output register: a load status, a released match,
    // or the final beat of a scan
    assign emit_beat = (state_reg == ST_IDLE)
                       ? (in_acc && !mode)
                       : (scan_done ? out_free : (hit && !scan_hold && pend_valid_reg));

    always_comb
    begin
        if (state_reg == ST_IDLE)
        begin
            idx_next = '0;
        end
        else if (!scan_done && !scan_hold)
        begin
            idx_next = idx_reg + CW'(1);
        end
        else
        begin
            idx_next = idx_reg;
        end
    end

    sirs_ram #(
        .WIDTH ($bits(sirs_pkg::entry_t)),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (eff_count[AW-1:0]),
        .wr_data (wr_entry),
        .rd_addr (idx_next[AW-1:0]),
        .rd_data (rd_entry)
    );

    // ---------------------------------------------------------------------
    // Sequencer, table bookkeeping and output register
    // ---------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            idx_reg        <= '0;
            last_key_reg   <= '0;
            last_vid_reg   <= '0;
            op_reg         <= '0;
            lo_reg         <= '0;
            has_hi_reg     <= 1'b0;
            hi_reg         <= '0;
            pend_reg       <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_kind_reg   <= sirs_pkg::KIND_LOADED;
            out_last_reg   <= 1'b0;
            out_entry_reg  <= '0;
        end
        else
        begin
            idx_reg <= idx_next;
            // raise valid on a new beat, drop it once the held beat is taken
            if (emit_beat)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_free)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (in_acc && !mode)
                    begin
                        out_last_reg  <= 1'b1;
                        out_entry_reg <= '0;
                        if (load_full)
                        begin
                            out_kind_reg <= sirs_pkg::KIND_DROPPED;
                        end
                        else if (load_bad)
                        begin
                            out_kind_reg <= sirs_pkg::KIND_REJECTED;
                        end
                        else
                        begin
                            out_kind_reg <= sirs_pkg::KIND_LOADED;
                        end
                        if (wr_en)
                        begin
                            count_reg    <= eff_count + CW'(1);
                            last_key_reg <= key_value;
                            last_vid_reg <= vertex_num;
                        end
                        else if (restart_table)
                        begin
                            count_reg <= '0;
                        end
                    end
                    else if (in_acc)
                    begin
                        op_reg         <= compare_op;
                        lo_reg         <= bound_low;
                        has_hi_reg     <= has_bound_high;
                        hi_reg         <= bound_high;
                        pend_valid_reg <= 1'b0;
                        state_reg      <= ST_SCAN;
                    end
                end

                ST_SCAN:
                begin
                    if (!scan_done)
                    begin
                        if (hit && !scan_hold)
                        begin
                            // release the held match, not last since another follows
                            if (pend_valid_reg)
                            begin
                                out_kind_reg  <= sirs_pkg::KIND_MATCH;
                                out_last_reg  <= 1'b0;
                                out_entry_reg <= pend_reg;
                            end
                            pend_reg       <= rd_entry;
                            pend_valid_reg <= 1'b1;
                        end
                    end
                    else if (out_free)
                    begin
                        out_last_reg <= 1'b1;
                        if (pend_valid_reg)
                        begin
                            out_kind_reg  <= sirs_pkg::KIND_MATCH;
                            out_entry_reg <= pend_reg;
                        end
                        else
                        begin
                            out_kind_reg  <= sirs_pkg::KIND_NOMATCH;
                            out_entry_reg <= '0;
                        end
                        pend_valid_reg <= 1'b0;
                        state_reg      <= ST_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign out_valid        = out_valid_reg;
    assign result_kind      = out_kind_reg;
    assign last_result      = out_last_reg;
    assign out_key          = out_entry_reg.key;
    assign out_vertex_id    = out_entry_reg.vid;
    assign out_valid_from   = out_entry_reg.from_time;
    assign out_has_valid_to = out_entry_reg.has_to;
    assign out_valid_to     = out_entry_reg.to_time;
    assign out_commit_seq   = out_entry_reg.commit;

    // ---------------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------------
    `ASSERT_CLKD(a_count_range, count_reg <= DEPTH_C, "posting count beyond table depth")
    `ASSERT_CLKD(a_status_last, out_valid_reg && (out_kind_reg != sirs_pkg::KIND_MATCH) |-> out_last_reg && (out_entry_reg == '0), "status beat not last or not zeroed")
    `ASSERT_CLKD(a_pend_idle, (state_reg == ST_IDLE) |-> !pend_valid_reg, "held match left over after scan")
    `ASSERT_CLKD(a_load_beat, in_acc && !mode |=> out_valid_reg && out_last_reg && (state_reg == ST_IDLE), "load gave no final beat")
    `ASSERT_CLK(a_reset_quiet, !rst_n |=> !out_valid_reg && (state_reg == ST_IDLE), "activity straight after reset")

endmodule

`default_nettype wire
